@@ hdl/aabb_collision_clip_unit_assert.svh @@
// ---------------------------------------------------------------------------
// aabb collision clip unit assertion macros
// concurrent assertion shorthands used by the top rtl file of the unit
// ---------------------------------------------------------------------------
`ifndef AABB_COLLISION_CLIP_UNIT_ASSERT_SVH
`define AABB_COLLISION_CLIP_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AABBCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define AABBCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/aabbcc_pkg.sv @@
// ---------------------------------------------------------------------------
// aabb collision clip package
// request modes and shared constants of the box collision and clip unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aabbcc_pkg;

    localparam int DEFAULT_COORD_WIDTH = 32;
    localparam int CLIP_MARGIN_WIDTH   = 16;
    localparam int MODE_WIDTH          = 3;
    localparam int NUM_AXES            = 3;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_LOAD      = 3'd0,
        MODE_MOVE      = 3'd1,
        MODE_EXPAND    = 3'd2,
        MODE_CLIP_X    = 3'd3,
        MODE_CLIP_Y    = 3'd4,
        MODE_CLIP_Z    = 3'd5,
        MODE_INTERSECT = 3'd6
    } t_mode;

endpackage

`default_nettype wire

@@ hdl/aabbcc_axis_clip.sv @@
// ---------------------------------------------------------------------------
// aabb collision clip, single axis limiter
// limits a displacement so the collider stops short of the held box
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabbcc_axis_clip #(
    parameter int COORD_WIDTH = aabbcc_pkg::DEFAULT_COORD_WIDTH
) (
    input  wire logic signed [COORD_WIDTH-1:0]                  i_lo,
    input  wire logic signed [COORD_WIDTH-1:0]                  i_hi,
    input  wire logic signed [COORD_WIDTH-1:0]                  i_clo,
    input  wire logic signed [COORD_WIDTH-1:0]                  i_chi,
    input  wire logic signed [COORD_WIDTH-1:0]                  i_delta,
    input  wire logic        [aabbcc_pkg::CLIP_MARGIN_WIDTH-1:0] i_margin,
    input  wire logic                                           i_gate,
    output logic signed      [COORD_WIDTH-1:0]                  o_delta
);

    localparam int XW = COORD_WIDTH + 2;

    logic signed [XW-1:0] lo_x, hi_x, clo_x, chi_x, d_x, m_x;
    logic signed [XW-1:0] t_gap;    // lo - chi - margin
    logic signed [XW-1:0] u_gap;    // margin - (clo - hi)
    logic signed [XW-1:0] d1;
    logic signed [XW-1:0] d2;
    logic                 step1, step2, d1_neg;
    logic                 u_gt_t, u_gt_d;

    assign lo_x  = {{2{i_lo[COORD_WIDTH-1]}}, i_lo};
    assign hi_x  = {{2{i_hi[COORD_WIDTH-1]}}, i_hi};
    assign clo_x = {{2{i_clo[COORD_WIDTH-1]}}, i_clo};
    assign chi_x = {{2{i_chi[COORD_WIDTH-1]}}, i_chi};
    assign d_x   = {{2{i_delta[COORD_WIDTH-1]}}, i_delta};
    assign m_x   = {{(XW-aabbcc_pkg::CLIP_MARGIN_WIDTH){1'b0}}, i_margin};

    assign t_gap = lo_x - chi_x - m_x;
    assign u_gap = m_x - clo_x + hi_x;

    // approaching from below: d = min(d, gap - margin)
    assign step1 = i_gate && (d_x > 0) && (chi_x <= lo_x) && (t_gap < d_x);
    assign d1    = step1 ? t_gap : d_x;

    // both candidates of the second compare are worked out in parallel
    assign u_gt_t = u_gap > t_gap;
    assign u_gt_d = u_gap > d_x;
    assign d1_neg = step1 ? t_gap[XW-1] : d_x[XW-1];

    // approaching from above: d = max(d, margin - gap)
    assign step2 = i_gate && d1_neg && (clo_x >= hi_x) && (step1 ? u_gt_t : u_gt_d);
    assign d2    = step2 ? u_gap : d1;

    assign o_delta = d2[COORD_WIDTH-1:0];

endmodule

`default_nettype wire

@@ hdl/aabb_collision_clip_unit.sv @@
// ---------------------------------------------------------------------------
// aabb collision clip unit
// holds one axis-aligned box; loads, moves, expands, clips and intersects
// ---------------------------------------------------------------------------
// usage:
//   requests enter on the s_axis channel: tuser carries the mode, tdata the
//   collider box faces and the three displacements. every request gives
//   exactly one result on m_axis: tdata holds the clipped displacement (zero
//   outside the clip modes), tuser the strict overlap flag of intersect.
//   clip_margin is written through i_cfg_wr_en / i_cfg_wr_data while idle.
// timing:
//   a request lands in an input register, is evaluated against the held box
//   by one pass of compare and saturating add logic, and its result goes to
//   the output register once that register is empty or being read.
//   one request per cycle is sustained while m_axis_tready is high; the box
//   update of a request is visible to the next one.
// reset:
//   synchronous, active low; box faces and clip_margin clear to zero and
//   both stages empty.
// stall:
//   while m_axis_tready is low the result holds, one more request is taken
//   into the input register, then s_axis_tready drops until the output moves.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "aabb_collision_clip_unit_assert.svh"

module aabb_collision_clip_unit #(
    parameter int COORD_WIDTH = aabbcc_pkg::DEFAULT_COORD_WIDTH,
    localparam int S_DATA_W   = ((9 * COORD_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W   = ((COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,

    input  wire logic                                       i_cfg_wr_en,
    input  wire logic [aabbcc_pkg::CLIP_MARGIN_WIDTH-1:0]   i_cfg_wr_data,

    input  wire logic                                       s_axis_tvalid,
    output logic                                            s_axis_tready,
    // other_x_lo, other_x_hi, other_y_lo, other_y_hi, other_z_lo,
    // other_z_hi, delta_x, delta_y, delta_z, zero pad
    input  wire logic [S_DATA_W-1:0]                        s_axis_tdata,
    // mode
    input  wire logic [aabbcc_pkg::MODE_WIDTH-1:0]          s_axis_tuser,

    output logic                                            m_axis_tvalid,
    input  wire logic                                       m_axis_tready,
    // clipped_delta, zero pad
    output logic [M_DATA_W-1:0]                             m_axis_tdata,
    // overlap_flag
    output logic                                            m_axis_tuser
);

    localparam int NA = aabbcc_pkg::NUM_AXES;
    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // configuration
    logic [aabbcc_pkg::CLIP_MARGIN_WIDTH-1:0] r_margin;

    // input stage
    logic                                  r_s1_valid;
    logic [aabbcc_pkg::MODE_WIDTH-1:0]     r_s1_mode;
    logic signed [COORD_WIDTH-1:0]         r_s1_clo   [NA];
    logic signed [COORD_WIDTH-1:0]         r_s1_chi   [NA];
    logic signed [COORD_WIDTH-1:0]         r_s1_delta [NA];

    // held box
    logic signed [COORD_WIDTH-1:0]         r_lo [NA];
    logic signed [COORD_WIDTH-1:0]         r_hi [NA];
    logic signed [COORD_WIDTH-1:0]         n_lo [NA];
    logic signed [COORD_WIDTH-1:0]         n_hi [NA];

    // result stage
    logic                                  r_out_valid;
    logic signed [COORD_WIDTH-1:0]         r_out_delta;
    logic                                  r_out_flag;
    logic signed [COORD_WIDTH-1:0]         n_out_delta;
    logic                                  n_out_flag;

    logic                                  s1_adv;
    logic                                  in_fire;
    logic [NA-1:0]                         ov;
    logic signed [COORD_WIDTH-1:0]         sat_lo [NA];
    logic signed [COORD_WIDTH-1:0]         sat_hi [NA];

    logic [1:0]                            clip_axis;
    logic                                  clip_gate;
    logic signed [COORD_WIDTH-1:0]         clip_res;

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // ---------------- configuration register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= '0;
        end else if (i_cfg_wr_en) begin
            r_margin <= i_cfg_wr_data;
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_mode <= s_axis_tuser;
            for (int a = 0; a < NA; a++) begin
                r_s1_clo[a]   <= s_axis_tdata[(2*a)*COORD_WIDTH +: COORD_WIDTH];
                r_s1_chi[a]   <= s_axis_tdata[(2*a+1)*COORD_WIDTH +: COORD_WIDTH];
                r_s1_delta[a] <= s_axis_tdata[(2*NA+a)*COORD_WIDTH +: COORD_WIDTH];
            end
        end
    end

    // ---------------- per-axis overlap and saturating face updates ----------------
    for (genvar a = 0; a < NA; a++) begin : g_axis
        logic signed [COORD_WIDTH:0]   sum_lo, sum_hi;
        logic signed [COORD_WIDTH-1:0] add_lo, add_hi;
        logic                          is_move;

        assign ov[a] = (r_s1_chi[a] > r_lo[a]) && (r_s1_clo[a] < r_hi[a]);

        // expand only pushes the face that the delta points at
        assign is_move = (r_s1_mode == aabbcc_pkg::MODE_MOVE);
        assign add_lo  = (is_move || r_s1_delta[a][COORD_WIDTH-1]) ? r_s1_delta[a] : '0;
        assign add_hi  = (is_move || (!r_s1_delta[a][COORD_WIDTH-1] && (r_s1_delta[a] != '0)))
                         ? r_s1_delta[a] : '0;

        assign sum_lo = {r_lo[a][COORD_WIDTH-1], r_lo[a]} + {add_lo[COORD_WIDTH-1], add_lo};
        assign sum_hi = {r_hi[a][COORD_WIDTH-1], r_hi[a]} + {add_hi[COORD_WIDTH-1], add_hi};

        assign sat_lo[a] = (sum_lo[COORD_WIDTH] == sum_lo[COORD_WIDTH-1])
                           ? sum_lo[COORD_WIDTH-1:0]
                           : (sum_lo[COORD_WIDTH] ? C_MIN : C_MAX);
        assign sat_hi[a] = (sum_hi[COORD_WIDTH] == sum_hi[COORD_WIDTH-1])
                           ? sum_hi[COORD_WIDTH-1:0]
                           : (sum_hi[COORD_WIDTH] ? C_MIN : C_MAX);
    end

    // ---------------- clip axis selection ----------------
    always_comb begin
        clip_axis = 2'd0;
        clip_gate = ov[1] && ov[2];
        unique case (aabbcc_pkg::t_mode'(r_s1_mode))
            aabbcc_pkg::MODE_CLIP_Y: begin
                clip_axis = 2'd1;
                clip_gate = ov[0] && ov[2];
            end
            aabbcc_pkg::MODE_CLIP_Z: begin
                clip_axis = 2'd2;
                clip_gate = ov[0] && ov[1];
            end
            default: begin
                clip_axis = 2'd0;
                clip_gate = ov[1] && ov[2];
            end
        endcase
    end

    aabbcc_axis_clip #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_axis_clip (
        .i_lo     (r_lo[clip_axis]),
        .i_hi     (r_hi[clip_axis]),
        .i_clo    (r_s1_clo[clip_axis]),
        .i_chi    (r_s1_chi[clip_axis]),
        .i_delta  (r_s1_delta[clip_axis]),
        .i_margin (r_margin),
        .i_gate   (clip_gate),
        .o_delta  (clip_res)
    );

    // ---------------- next box and result ----------------
    always_comb begin
        n_out_delta = '0;
        n_out_flag  = 1'b0;
        for (int a = 0; a < NA; a++) begin
            n_lo[a] = r_lo[a];
            n_hi[a] = r_hi[a];
        end
        unique case (aabbcc_pkg::t_mode'(r_s1_mode))
            aabbcc_pkg::MODE_LOAD: begin
                for (int a = 0; a < NA; a++) begin
                    n_lo[a] = r_s1_clo[a];
                    n_hi[a] = r_s1_chi[a];
                end
            end
            aabbcc_pkg::MODE_MOVE, aabbcc_pkg::MODE_EXPAND: begin
                for (int a = 0; a < NA; a++) begin
                    n_lo[a] = sat_lo[a];
                    n_hi[a] = sat_hi[a];
                end
            end
            aabbcc_pkg::MODE_CLIP_X, aabbcc_pkg::MODE_CLIP_Y, aabbcc_pkg::MODE_CLIP_Z: begin
                n_out_delta = clip_res;
            end
            aabbcc_pkg::MODE_INTERSECT: begin
                n_out_flag = &ov;
            end
            default: begin
                // unused mode: box untouched, zero result
                n_out_delta = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NA; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
        end else if (s1_adv) begin
            for (int a = 0; a < NA; a++) begin
                r_lo[a] <= n_lo[a];
                r_hi[a] <= n_hi[a];
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_delta <= n_out_delta;
            r_out_flag  <= n_out_flag;
        end
    end

    always_comb begin
        m_axis_tdata                  = '0;
        m_axis_tdata[COORD_WIDTH-1:0] = r_out_delta;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_flag;

    // ---------------- assertions ----------------
    `AABBCC_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n,
        r_s1_valid && r_out_valid && !m_axis_tready, !s_axis_tready,
        "input taken while both stages are full and output stalled")

    `AABBCC_ASSERT_NXT(a_advance_fills_output, i_clk, i_rst_n,
        s1_adv, r_out_valid,
        "advanced request did not reach the output register")

    `AABBCC_ASSERT_NXT(a_load_sets_box, i_clk, i_rst_n,
        s1_adv && (r_s1_mode == aabbcc_pkg::MODE_LOAD),
        (r_lo[0] == $past(r_s1_clo[0])) && (r_hi[2] == $past(r_s1_chi[2])),
        "load request did not replace the box")

    `AABBCC_ASSERT_NXT(a_query_keeps_box, i_clk, i_rst_n,
        s1_adv && (r_s1_mode != aabbcc_pkg::MODE_LOAD)
            && (r_s1_mode != aabbcc_pkg::MODE_MOVE)
            && (r_s1_mode != aabbcc_pkg::MODE_EXPAND),
        $stable(r_lo[0]) && $stable(r_hi[0]) && $stable(r_lo[1])
            && $stable(r_hi[1]) && $stable(r_lo[2]) && $stable(r_hi[2]),
        "clip or intersect request changed the box")

    `AABBCC_ASSERT_IMP(a_flag_excludes_delta, i_clk, i_rst_n,
        r_out_valid && r_out_flag, r_out_delta == '0,
        "overlap flag and clipped delta both set")

endmodule

`default_nettype wire
